FILE: design/gnw_pkg.sv
// ----------------------------------------------------------------------------
// gnw_pkg
// Shared constants for the grid node walk address generator.
// ----------------------------------------------------------------------------
package gnw_pkg;

   localparam int MAX_TICKS = 1024;

   localparam int TICK_W   = 11;
   localparam int COORD_W  = 12;
   localparam int ORDER_W  = 22;
   localparam int IDX_W    = 3;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   localparam logic [IDX_W-1:0] REG_TICKS_X   = 3'd0;
   localparam logic [IDX_W-1:0] REG_TICKS_Y   = 3'd1;
   localparam logic [IDX_W-1:0] REG_CORE_X    = 3'd2;
   localparam logic [IDX_W-1:0] REG_CORE_Y    = 3'd3;
   localparam logic [IDX_W-1:0] REG_WALK_MODE = 3'd4;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_ADVANCE = 2'd1;
   localparam logic [1:0] CMD_QUERY   = 2'd2;
   localparam logic [1:0] CMD_NOP     = 2'd3;

   localparam logic [3:0] NB_CENTRE = 4'd0;
   localparam logic [3:0] NB_PX     = 4'd1;
   localparam logic [3:0] NB_PX_MY  = 4'd2;
   localparam logic [3:0] NB_MY     = 4'd3;
   localparam logic [3:0] NB_MX_MY  = 4'd4;
   localparam logic [3:0] NB_MX     = 4'd5;
   localparam logic [3:0] NB_MX_PY  = 4'd6;
   localparam logic [3:0] NB_PY     = 4'd7;
   localparam logic [3:0] NB_PX_PY  = 4'd8;

   localparam logic [TICK_W-1:0] TICKS_RESET = 11'd16;

endpackage

FILE: design/grid_node_walk_address_generator.sv
// ----------------------------------------------------------------------------
// grid_node_walk_address_generator
// Two-dimensional stencil node walker: restart, raster or perimeter advance,
// and nine-point neighbour query, one node position per word.
// ----------------------------------------------------------------------------
// One request word is taken per clock while the response side is not stalled. Its
// response is presented after the word has passed three registers (input register,
// state update stage, order multiply stage). The sustained rate is one word
// per cycle while rsp_tready holds, with the current node register updated as each word passes.
// Each stage holds its word only while the stage ahead is full and stalled.
// The user must write registers through the csr port only while the block is
// idle; the block itself does not enforce it. There is no clearing pass after reset.
module grid_node_walk_address_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gnw_pkg::REQ_DATA_W-1:0]      req_tdata,  // [3:0] neighbour_pos
   input  logic [gnw_pkg::REQ_USER_W-1:0]      req_tuser,  // [1:0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gnw_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [11:0] x_tick, [23:12] y_tick,
                                                           // [45:24] order
   output logic [gnw_pkg::RSP_USER_W-1:0]      rsp_tuser,  // [0] done_res
   input  logic                                csr_we,
   input  logic [gnw_pkg::IDX_W-1:0]           csr_index,
   input  logic [gnw_pkg::TICK_W-1:0]          csr_wdata
);
   import gnw_pkg::*;

   // configuration
   logic [TICK_W-1:0] ticks_x_ff, ticks_y_ff;
   logic              core_x_ff, core_y_ff, walk_mode_ff;

   // walk state
   logic [TICK_W-1:0] cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;

   // stage 1: input register
   logic              v1_ff;
   logic [1:0]        cmd1_ff;
   logic [3:0]        pos1_ff;

   // stage 2: node and order operands
   logic                      v2_ff;
   logic signed [COORD_W:0]   x2_ff, x2_in;
   logic signed [COORD_W:0]   yrel2_ff, yrel2_in;
   logic signed [COORD_W:0]   y2_ff, y2_in;
   logic [TICK_W-1:0]         span2_ff;
   logic                      base2_ff, done2_ff, done2_in;

   // stage 3: result register
   logic                      v3_ff;
   logic [COORD_W-1:0]        x3_ff, y3_ff;
   logic [ORDER_W-1:0]        order3_ff, order3_in;
   logic                      done3_ff;

   logic ready1, ready2, ready3, move1, move2, move3;

   logic [TICK_W-1:0] eff_x, eff_y, last_x, last_y, span_x;
   logic [TICK_W-1:0] fx, fy;
   logic              done_cur;
   logic [1:0]        dx, dy;

   assign ready3 = !v3_ff || rsp_tready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign move1  = req_tvalid && ready1;
   assign move2  = v1_ff && ready2;
   assign move3  = v2_ff && ready3;
   assign req_tready = ready1;

   function automatic logic [TICK_W-1:0] eff_ticks(input logic [TICK_W-1:0] t);
      logic [TICK_W-1:0] r;
      if (t < TICK_W'(3)) begin
         r = TICK_W'(3);
      end else if (32'(t) > MAX_TICKS) begin
         r = TICK_W'(MAX_TICKS);
      end else begin
         r = t;
      end
      return r;
   endfunction

   assign eff_x  = eff_ticks(ticks_x_ff);
   assign eff_y  = eff_ticks(ticks_y_ff);
   assign last_x = core_x_ff ? eff_x - TICK_W'(2) : eff_x - TICK_W'(1);
   assign last_y = core_y_ff ? eff_y - TICK_W'(2) : eff_y - TICK_W'(1);
   assign span_x = core_x_ff ? eff_x - TICK_W'(2) : eff_x;
   assign fx     = TICK_W'(core_x_ff);
   assign fy     = TICK_W'(core_y_ff);
   assign done_cur = (cur_x_ff > last_x) && (cur_y_ff > last_y);

   always_comb begin
      logic [TICK_W:0] rx, ry;
      rx = '0;
      ry = '0;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      unique case (cmd1_ff)
         CMD_RESTART: begin
            cur_x_in = fx;
            cur_y_in = fy;
         end
         CMD_ADVANCE: begin
            if (!done_cur && !walk_mode_ff) begin
               rx = {1'b0, cur_x_ff} + (TICK_W+1)'(1);
               ry = {1'b0, cur_y_ff};
               if (rx > {1'b0, last_x}) begin
                  ry = ry + (TICK_W+1)'(1);
                  if (ry <= {1'b0, last_y}) begin
                     rx = {1'b0, fx};
                  end
               end
               cur_x_in = rx[TICK_W-1:0];
               cur_y_in = ry[TICK_W-1:0];
            end else if (!done_cur) begin
               if (cur_y_ff == fy) begin
                  if (cur_x_ff < last_x) begin
                     cur_x_in = cur_x_ff + TICK_W'(1);
                  end else begin
                     cur_y_in = cur_y_ff + TICK_W'(1);
                     cur_x_in = fx;
                  end
               end else if (cur_y_ff > fy && cur_y_ff < last_y) begin
                  if (cur_x_ff == fx) begin
                     cur_x_in = last_x;
                  end else begin
                     cur_y_in = cur_y_ff + TICK_W'(1);
                     cur_x_in = fx;
                  end
               end else if (cur_y_ff == last_y) begin
                  if (cur_x_ff < last_x) begin
                     cur_x_in = cur_x_ff + TICK_W'(1);
                  end else begin
                     cur_x_in = last_x + TICK_W'(1);
                     cur_y_in = last_y + TICK_W'(1);
                  end
               end
            end
         end
         CMD_QUERY, CMD_NOP: begin
         end
      endcase
   end

   always_comb begin
      dx = 2'b00;
      dy = 2'b00;
      if (cmd1_ff == CMD_QUERY) begin
         unique case (pos1_ff)
            NB_PX:    begin dx = 2'b01; dy = 2'b00; end
            NB_PX_MY: begin dx = 2'b01; dy = 2'b11; end
            NB_MY:    begin dx = 2'b00; dy = 2'b11; end
            NB_MX_MY: begin dx = 2'b11; dy = 2'b11; end
            NB_MX:    begin dx = 2'b11; dy = 2'b00; end
            NB_MX_PY: begin dx = 2'b11; dy = 2'b01; end
            NB_PY:    begin dx = 2'b00; dy = 2'b01; end
            NB_PX_PY: begin dx = 2'b01; dy = 2'b01; end
            default:  begin dx = 2'b00; dy = 2'b00; end
         endcase
      end
   end

   assign x2_in    = $signed({2'b00, cur_x_in}) + $signed({{(COORD_W-1){dx[1]}}, dx});
   assign y2_in    = $signed({2'b00, cur_y_in}) + $signed({{(COORD_W-1){dy[1]}}, dy});
   assign yrel2_in = y2_in - $signed({2'b00, fy});
   assign done2_in = (cur_x_in > last_x) && (cur_y_in > last_y);

   always_comb begin
      logic signed [2*COORD_W:0] prod, sum;
      prod = yrel2_ff * $signed({1'b0, span2_ff});
      sum  = prod + (2*COORD_W+1)'(x2_ff) + (2*COORD_W+1)'({1'b0, base2_ff});
      order3_in = sum[ORDER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_x_ff   <= TICKS_RESET;
         ticks_y_ff   <= TICKS_RESET;
         core_x_ff    <= 1'b1;
         core_y_ff    <= 1'b1;
         walk_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TICKS_X:   ticks_x_ff   <= csr_wdata;
            REG_TICKS_Y:   ticks_y_ff   <= csr_wdata;
            REG_CORE_X:    core_x_ff    <= csr_wdata[0];
            REG_CORE_Y:    core_y_ff    <= csr_wdata[0];
            REG_WALK_MODE: walk_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_tvalid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (move2) begin
            cur_x_ff <= cur_x_in;
            cur_y_ff <= cur_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         cmd1_ff <= req_tuser[1:0];
         pos1_ff <= req_tdata[3:0];
      end
      if (move2) begin
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         yrel2_ff <= yrel2_in;
         span2_ff <= span_x;
         base2_ff <= !core_x_ff;
         done2_ff <= done2_in;
      end
      if (move3) begin
         x3_ff     <= x2_ff[COORD_W-1:0];
         y3_ff     <= y2_ff[COORD_W-1:0];
         order3_ff <= order3_in;
         done3_ff  <= done2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {(RSP_DATA_W-2*COORD_W-ORDER_W)'(0), order3_ff, y3_ff, x3_ff};
   assign rsp_tuser  = done3_ff;

   // node moves only when a word passes the update stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !move2 |=> $stable(cur_x_ff) && $stable(cur_y_ff))
      else $error("walk state changed without a word");

   // restart lands on the first node
   a_restart: assert property (@(posedge clock) disable iff (reset)
      move2 && cmd1_ff == CMD_RESTART |=>
         cur_x_ff == $past(fx) && cur_y_ff == $past(fy))
      else $error("restart did not reach first node");

   // advance past the end leaves the node in place
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      move2 && cmd1_ff == CMD_ADVANCE && done_cur |=>
         $stable(cur_x_ff) && $stable(cur_y_ff))
      else $error("advance moved a finished walk");

   // an empty input stage always takes a word
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("empty input stage refused a word");

endmodule
